FILE: hdl/lkvc_pkg.sv
package lkvc_pkg;

    // 32-bit signed word carried by the key and value fields
    typedef logic signed [31:0] word_t;

    // operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // configuration map
    localparam int unsigned ADDR_BITS    = 3;
    localparam logic        REG_CAPACITY = 1'b0;
    localparam int unsigned CAP_BITS     = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // read data returned by a get that misses
    localparam word_t MISS_VALUE = -32'sd1;

endpackage

FILE: hdl/lkvc_cmd_if.sv
interface lkvc_cmd_if;
    logic                valid;
    logic                ready;
    logic                opcode;
    lkvc_pkg::word_t     lookup_key;
    lkvc_pkg::word_t     write_value;

    modport source (output valid, output opcode, output lookup_key, output write_value,
                    input ready);
    modport sink   (input valid, input opcode, input lookup_key, input write_value,
                    output ready);
endinterface

FILE: hdl/lkvc_rsp_if.sv
interface lkvc_rsp_if;
    logic                valid;
    logic                ready;
    logic                hit;
    lkvc_pkg::word_t     read_value;
    logic                evicted;
    lkvc_pkg::word_t     evicted_key;

    modport source (output valid, output hit, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input hit, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface

FILE: hdl/lru_key_value_cache_top.sv
// Channel   Role          Transfer when         Payload
// cmd       sink          valid & ready         opcode, lookup_key, write_value
// rsp       source        valid & ready         hit, read_value, evicted, evicted_key
// apb       config slave  psel&penable&pwrite   capacity_in_use at byte address 0
//
// One operation completes per cycle while rsp is not stalled: a command is held in the
// input register, the tag match, rank update and victim pick run in one pass, and state
// and the result register are written at the same edge; rsp presents the result register.
// Reset empties the store at once (valid bits in flip-flops, no clearing pass).
// A stalled rsp holds the result; cmd still takes one more transfer into the input
// register, then stalls until the result register frees up.
module lru_key_value_cache_top #(
    parameter int unsigned ENTRIES  = 16,
    parameter int unsigned KEY_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    lkvc_cmd_if.sink                           cmd,
    lkvc_rsp_if.source                         rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lkvc_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int unsigned RANK_BITS  = $clog2(ENTRIES);
    localparam int unsigned COUNT_BITS = $clog2(ENTRIES + 1);
    localparam int unsigned CMP_BITS   =
        (COUNT_BITS > lkvc_pkg::CAP_BITS) ? COUNT_BITS : lkvc_pkg::CAP_BITS;
    localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(ENTRIES);

    // ---------------------------------------------------------------- config
    logic [lkvc_pkg::CAP_BITS-1:0] cap_reg;
    logic                          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lkvc_pkg::CAP_RESET;
        end
        else if (cfg_wr && (paddr[2] == lkvc_pkg::REG_CAPACITY))
        begin
            cap_reg <= pwdata[lkvc_pkg::CAP_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == lkvc_pkg::REG_CAPACITY)
                  ? {{(32 - lkvc_pkg::CAP_BITS){1'b0}}, cap_reg} : 32'd0;

    // ---------------------------------------------------------- input stage
    logic                  in_valid_reg;
    logic                  op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    lkvc_pkg::word_t       val_reg;
    logic                  out_valid_reg;
    logic                  advance;

    // move the held command into the result register when there is room
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign cmd.ready = !in_valid_reg || advance;

    logic [63:0] key_wide;
    assign key_wide = {{32{cmd.lookup_key[31]}}, cmd.lookup_key};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            op_reg  <= cmd.opcode;
            key_reg <= key_wide[KEY_BITS-1:0];
            val_reg <= cmd.write_value;
        end
    end

    // ----------------------------------------------------------- store
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [RANK_BITS-1:0]  rank_reg  [ENTRIES];
    logic [RANK_BITS-1:0]  rank_next [ENTRIES];
    logic [KEY_BITS-1:0]   tag_reg   [ENTRIES];
    logic [KEY_BITS-1:0]   tag_next  [ENTRIES];
    lkvc_pkg::word_t       data_reg  [ENTRIES];
    lkvc_pkg::word_t       data_next [ENTRIES];
    logic [COUNT_BITS-1:0] count_reg, count_next;

    // match, victim and free-slot vectors
    logic [ENTRIES-1:0]    match_vec, match_oh;
    logic [ENTRIES-1:0]    victim_oh, free_vec, slot_oh;
    logic                  is_hit, is_put, need_evict, do_evict;
    logic [RANK_BITS-1:0]  hit_rank, lru_rank;
    lkvc_pkg::word_t       hit_data;
    logic [KEY_BITS-1:0]   victim_tag;
    logic [63:0]           victim_wide;
    logic [CMP_BITS-1:0]   count_ext, cap_ext;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i] = valid_reg[i] && (tag_reg[i] == key_reg);
        end
    end

    // lowest matching entry; keys are unique so at most one bit is set anyway
    assign match_oh = match_vec & (~match_vec + 1'b1);
    assign is_hit   = |match_vec;
    assign is_put   = (op_reg == lkvc_pkg::OP_PUT);

    // the least recent valid entry carries rank count-1
    assign lru_rank = RANK_BITS'(count_reg - 1'b1);

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            victim_oh[i] = valid_reg[i] && (rank_reg[i] == lru_rank);
        end
    end

    always_comb
    begin
        hit_rank   = '0;
        hit_data   = '0;
        victim_tag = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_rank   = hit_rank   | (rank_reg[i] & {RANK_BITS{match_oh[i]}});
            hit_data   = hit_data   | (data_reg[i] & {32{match_oh[i]}});
            victim_tag = victim_tag | (tag_reg[i]  & {KEY_BITS{victim_oh[i]}});
        end
    end

    // capacity zero acts as one; above ENTRIES the full store caps it
    assign count_ext  = CMP_BITS'(count_reg);
    assign cap_ext    = (cap_reg == '0) ? CMP_BITS'(1) : CMP_BITS'(cap_reg);
    assign need_evict = (count_ext >= cap_ext) || (count_reg == FULL_COUNT);
    assign do_evict   = is_put && !is_hit && need_evict && (|victim_oh);

    assign free_vec   = ~valid_reg | (do_evict ? victim_oh : '0);
    assign slot_oh    = free_vec & (~free_vec + 1'b1);

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            tag_next[i]  = tag_reg[i];
            data_next[i] = data_reg[i];
        end
        if (advance)
        begin
            if (is_hit)
            begin
                // promote the hit entry, age the ones that were more recent
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (match_oh[i])
                    begin
                        rank_next[i] = '0;
                        if (is_put)
                        begin
                            data_next[i] = val_reg;
                        end
                    end
                    else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                    begin
                        rank_next[i] = RANK_BITS'(rank_reg[i] + 1'b1);
                    end
                end
            end
            else if (is_put)
            begin
                // drop the victim, age the survivors, insert at the lowest free slot
                valid_next = valid_reg & ~(do_evict ? victim_oh : '0);
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (slot_oh[i])
                    begin
                        rank_next[i] = '0;
                        tag_next[i]  = key_reg;
                        data_next[i] = val_reg;
                    end
                    else if (valid_next[i])
                    begin
                        rank_next[i] = RANK_BITS'(rank_reg[i] + 1'b1);
                    end
                end
                valid_next = valid_next | slot_oh;
                count_next = COUNT_BITS'(count_reg - COUNT_BITS'(do_evict)
                                                   + COUNT_BITS'(|slot_oh));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_reg[i] <= rank_next[i];
            tag_reg[i]  <= tag_next[i];
            data_reg[i] <= data_next[i];
        end
    end

    // ------------------------------------------------------- result stage
    logic            hit_reg;
    lkvc_pkg::word_t rd_reg;
    logic            ev_reg;
    lkvc_pkg::word_t evk_reg;

    assign victim_wide = 64'(victim_tag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit_reg <= is_hit;
            if (is_put)
            begin
                rd_reg <= '0;
            end
            else
            begin
                rd_reg <= is_hit ? hit_data : lkvc_pkg::MISS_VALUE;
            end
            ev_reg  <= do_evict;
            evk_reg <= do_evict ? victim_wide[31:0] : '0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = hit_reg;
    assign rsp.read_value  = rd_reg;
    assign rsp.evicted     = ev_reg;
    assign rsp.evicted_key = evk_reg;

`ifndef SYNTHESIS
    a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == COUNT_BITS'($countones(valid_reg)))
        else $error("entry count does not match valid bits");

    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> $onehot0(match_vec))
        else $error("key present in more than one entry");

    a_full_put_evicts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_put && !is_hit && (count_reg == FULL_COUNT) |-> do_evict)
        else $error("put of new key into full store did not evict");

    a_victim_single: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> $onehot(victim_oh))
        else $error("least recent entry is not unique");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not loaded after advance");
`endif

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int unsigned ENTRIES     = 16;
    localparam int unsigned KEY_BITS    = 32;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_SLACK = 6;   // cycles past the last response
    localparam int          HOLD_CYCLES = 150; // length of the long response hold-off
    localparam int          PHASE_OPS   = 175;

    // one command as offered on the cmd channel
    typedef struct packed {
        logic            opcode;
        lkvc_pkg::word_t lookup_key;
        lkvc_pkg::word_t write_value;
    } cache_op_t;

    // one response as seen on the rsp channel
    typedef struct packed {
        logic            hit;
        lkvc_pkg::word_t read_value;
        logic            evicted;
        lkvc_pkg::word_t evicted_key;
    } cache_rsp_t;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [lkvc_pkg::ADDR_BITS-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    lkvc_cmd_if cmd_bus();
    lkvc_rsp_if rsp_bus();

    lru_key_value_cache_top #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_bus),
        .rsp     (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the cache: slot contents, recency ranks (0 = most recent),
    // occupancy and the capacity register as last written.
    logic                          mirror_valid [ENTRIES];
    lkvc_pkg::word_t               mirror_key   [ENTRIES];
    lkvc_pkg::word_t               mirror_value [ENTRIES];
    int                            mirror_rank  [ENTRIES];
    int                            mirror_count;
    logic [lkvc_pkg::CAP_BITS-1:0] mirror_cap;

    cache_op_t  ops_pending[$];     // commands waiting for the cmd driver
    cache_rsp_t lookups_due[$];     // predicted responses, oldest first
    cache_op_t  staged_op;

    int  ops_queued;
    int  ops_taken;
    bit  cmd_taken;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_asked;
    int  hold_served;
    int  hold_left;
    int  mismatches;
    int  cycle_count;
    int  hits_seen;
    int  evictions_seen;
    int  cap_writes;

    // Free-running clock, 10 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Bump a slot to most recent; age every valid slot that was more recent.
    function automatic void promote_slot(int s);
        for (int i = 0; i < ENTRIES; i++)
            if (mirror_valid[i] && mirror_rank[i] < mirror_rank[s])
                mirror_rank[i]++;
        mirror_rank[s] = 0;
    endfunction

    // Apply one operation to the shadow cache and return the response it owes.
    function automatic cache_rsp_t cache_predict(cache_op_t op);
        cache_rsp_t r;
        int         found;
        int         victim;
        int         slot;
        int         limit;
        r.hit         = 1'b0;
        r.read_value  = '0;
        r.evicted     = 1'b0;
        r.evicted_key = '0;
        found = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && mirror_valid[i] && mirror_key[i] == op.lookup_key)
                found = i;
        if (op.opcode == lkvc_pkg::OP_GET)
        begin
            if (found >= 0)
            begin
                r.hit        = 1'b1;
                r.read_value = mirror_value[found];
                promote_slot(found);
            end
            else
                r.read_value = lkvc_pkg::MISS_VALUE;
        end
        else if (found >= 0)
        begin
            r.hit               = 1'b1;
            mirror_value[found] = op.write_value;
            promote_slot(found);
        end
        else
        begin
            // zero capacity acts as one, anything past the store size saturates
            limit = (mirror_cap == 0) ? 1 : (mirror_cap > ENTRIES) ? ENTRIES : int'(mirror_cap);
            if (mirror_count >= limit)
            begin
                victim = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (mirror_valid[i] && (victim < 0 || mirror_rank[i] >= mirror_rank[victim]))
                        victim = i;
                if (victim >= 0)
                begin
                    r.evicted            = 1'b1;
                    r.evicted_key        = mirror_key[victim];
                    mirror_valid[victim] = 1'b0;
                    mirror_count--;
                end
            end
            // new key goes into the lowest free slot as most recent
            slot = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && !mirror_valid[i])
                    slot = i;
            if (slot >= 0)
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (mirror_valid[i])
                        mirror_rank[i]++;
                mirror_valid[slot] = 1'b1;
                mirror_key[slot]   = op.lookup_key;
                mirror_value[slot] = op.write_value;
                mirror_rank[slot]  = 0;
                mirror_count++;
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, lkvc_pkg::word_t want, lkvc_pkg::word_t got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Cmd driver: present a new command once the previous one transferred,
    // or idle at the configured rate. Drive once per falling edge.
    always @(negedge clk)
    begin
        if (rst_n && (!cmd_bus.valid || cmd_taken))
        begin
            if (ops_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                staged_op = ops_pending.pop_front();
                cmd_bus.valid       <= 1'b1;
                cmd_bus.opcode      <= staged_op.opcode;
                cmd_bus.lookup_key  <= staged_op.lookup_key;
                cmd_bus.write_value <= staged_op.write_value;
            end
            else
                cmd_bus.valid <= 1'b0;
        end
    end

    // Rsp ready: honor a long hold-off when one is asked for, counting it
    // down here; otherwise stall at random at the configured rate.
    always @(negedge clk)
    begin
        if (hold_asked != hold_served)
        begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
        end
        else
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Cmd monitor: predict the response of every accepted transfer.
    always @(posedge clk)
    begin
        cmd_taken <= cmd_bus.valid && cmd_bus.ready;
        if (rst_n && cmd_bus.valid && cmd_bus.ready)
        begin
            lookups_due.push_back(cache_predict('{cmd_bus.opcode, cmd_bus.lookup_key,
                                                  cmd_bus.write_value}));
            ops_taken++;
        end
    end

    // Rsp monitor: compare each transfer against the oldest prediction.
    always @(posedge clk)
    begin
        cache_rsp_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (lookups_due.size() == 0)
            begin
                $display("%0t: response with nothing expected, got hit=%b read=%h ev=%b key=%h",
                         $time, rsp_bus.hit, rsp_bus.read_value, rsp_bus.evicted,
                         rsp_bus.evicted_key);
                mismatches++;
            end
            else
            begin
                want = lookups_due.pop_front();
                check_field("hit", lkvc_pkg::word_t'(want.hit),
                            lkvc_pkg::word_t'(rsp_bus.hit));
                check_field("read_value", want.read_value, rsp_bus.read_value);
                check_field("evicted", lkvc_pkg::word_t'(want.evicted),
                            lkvc_pkg::word_t'(rsp_bus.evicted));
                check_field("evicted_key", want.evicted_key, rsp_bus.evicted_key);
            end
            if (rsp_bus.hit === 1'b1)
                hits_seen++;
            if (rsp_bus.evicted === 1'b1)
                evictions_seen++;
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic queue_op(logic opcode, lkvc_pkg::word_t key, lkvc_pkg::word_t value);
        ops_pending.push_back('{opcode, key, value});
        ops_queued++;
    endtask

    // Wait until every command transferred and every response came back,
    // then give the pipeline DRAIN_SLACK as slack to settle.
    task automatic drain();
        while (ops_pending.size() != 0 || ops_taken != ops_queued || lookups_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_SLACK) @(negedge clk);
    endtask

    // APB write of the capacity register: setup cycle, then access cycle.
    task automatic write_capacity(logic [31:0] word);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lkvc_pkg::ADDR_BITS'(int'(lkvc_pkg::REG_CAPACITY) * 4);
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mirror_cap = word[lkvc_pkg::CAP_BITS-1:0];
        cap_writes++;
    endtask

    // Random phase: mostly keys from a small pool sized around the capacity
    // so hits, overwrites and evictions are frequent; the rest fully random.
    task automatic run_phase(logic [31:0] cap_word, int idle, int stall, bit squeeze);
        lkvc_pkg::word_t key_pool[$];
        int              pool_size;
        lkvc_pkg::word_t key;
        write_capacity(cap_word);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        pool_size = (mirror_cap == 0) ? 1 : (mirror_cap > ENTRIES) ? ENTRIES : int'(mirror_cap);
        pool_size = pool_size + 4;
        for (int i = 0; i < pool_size; i++)
            key_pool.push_back(lkvc_pkg::word_t'($urandom()));
        for (int n = 0; n < PHASE_OPS; n++)
        begin
            if ($urandom_range(99) < 12)
                key = lkvc_pkg::word_t'($urandom());
            else
                key = key_pool[$urandom_range(pool_size - 1)];
            queue_op($urandom_range(1) ? lkvc_pkg::OP_PUT : lkvc_pkg::OP_GET, key,
                     lkvc_pkg::word_t'($urandom()));
        end
        // stall the response side while the sender keeps pushing
        if (squeeze)
            hold_asked++;
        drain();
    endtask

    initial
    begin
        // drive every input to a known value before reset lets go
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        cmd_bus.valid       = 1'b0;
        cmd_bus.opcode      = lkvc_pkg::OP_GET;
        cmd_bus.lookup_key  = '0;
        cmd_bus.write_value = '0;
        rsp_bus.ready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_asked     = 0;
        hold_served    = 0;
        hold_left      = 0;
        mismatches     = 0;
        cycle_count    = 0;
        ops_queued     = 0;
        ops_taken      = 0;
        hits_seen      = 0;
        evictions_seen = 0;
        cap_writes     = 0;
        cmd_taken      = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            mirror_valid[i] = 1'b0;
            mirror_key[i]   = '0;
            mirror_value[i] = '0;
            mirror_rank[i]  = 0;
        end
        mirror_count = 0;
        mirror_cap   = lkvc_pkg::CAP_RESET;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: miss on an empty store, key and value extremes, a get that
        // hits a stored all-ones value, overwrite of a present key.
        queue_op(lkvc_pkg::OP_GET, 32'sh0000_0000, 32'sh1234_5678);
        queue_op(lkvc_pkg::OP_PUT, 32'sh8000_0000, 32'sh7FFF_FFFF);
        queue_op(lkvc_pkg::OP_PUT, 32'sh7FFF_FFFF, 32'sh8000_0000);
        queue_op(lkvc_pkg::OP_PUT, 32'sh0000_0000, 32'sh0000_0000);
        queue_op(lkvc_pkg::OP_PUT, -32'sd1, -32'sd1);
        queue_op(lkvc_pkg::OP_GET, 32'sh8000_0000, 32'sh0000_0000);
        queue_op(lkvc_pkg::OP_GET, -32'sd1, 32'sh0000_0000);
        queue_op(lkvc_pkg::OP_PUT, 32'sh8000_0000, 32'sh1234_5678);
        queue_op(lkvc_pkg::OP_GET, 32'sh8000_0000, -32'sd1);
        queue_op(lkvc_pkg::OP_GET, 32'sh0000_0001, 32'sh0000_0000);
        queue_op(lkvc_pkg::OP_GET, 32'sh7FFF_FFFF, 32'sh0000_0000);

        // Capacity dropped below the occupancy: each new key evicts exactly
        // one least recent entry, a present key evicts nothing.
        write_capacity(32'd1);
        queue_op(lkvc_pkg::OP_PUT, 32'sh5555_5555, 32'shAAAA_AAAA);
        queue_op(lkvc_pkg::OP_PUT, 32'shAAAA_AAAA, 32'sh5555_5555);
        queue_op(lkvc_pkg::OP_GET, 32'sh5555_5555, 32'sh0000_0000);
        queue_op(lkvc_pkg::OP_PUT, 32'sh5555_5555, 32'sh0F0F_0F0F);
        queue_op(lkvc_pkg::OP_GET, 32'sh0000_0000, 32'sh0000_0000);

        // Zero capacity behaves as one.
        write_capacity(32'd0);
        queue_op(lkvc_pkg::OP_PUT, 32'sh0000_0002, 32'sh0000_0002);
        queue_op(lkvc_pkg::OP_PUT, 32'sh0000_0003, 32'sh0000_0003);
        queue_op(lkvc_pkg::OP_GET, 32'sh0000_0002, 32'sh0000_0000);
        queue_op(lkvc_pkg::OP_PUT, 32'sh0000_0004, 32'sh0000_0004);

        // Random phases across capacity settings (31 saturates, the all-ones
        // upper bits are dropped) and every idle/stall mix.
        run_phase(32'd31, 0, 0, 1'b0);
        run_phase(32'd16, 83, 0, 1'b0);
        run_phase(32'd3, 0, 83, 1'b0);
        run_phase(32'hFFFF_FFE0, 20, 20, 1'b0);
        run_phase(32'd8, 0, 0, 1'b1);
        run_phase(32'hFFFF_FFEC, 0, 0, 1'b0);

        drain();
        $display("covered %0d operations over %0d capacity writes", ops_taken, cap_writes);
        $display("responses with a hit: %0d, with an eviction: %0d", hits_seen, evictions_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/lkvc_pkg.sv
hdl/lkvc_cmd_if.sv
hdl/lkvc_rsp_if.sv
hdl/lru_key_value_cache_top.sv
bench/tb.sv
